// ===== sv/edh_pkg.sv =====
// shared types, constants and codes of the echo delay with highpass block
package edh_pkg;

  localparam int unsigned DelayDepthDef = 131072;
  localparam int unsigned SampleBitsDef = 24;

  localparam int unsigned DelayBits   = 17;
  localparam int unsigned GainBits    = 17;
  localparam int unsigned CoefBits    = 24;
  localparam int unsigned HistYBits   = 32;
  localparam int unsigned MulABits    = 33;
  localparam int unsigned MulBBits    = 25;
  localparam int unsigned ProdBits    = MulABits + MulBBits;
  localparam int unsigned AccBits     = 60;
  localparam int unsigned GainShift   = 16;
  localparam int unsigned CoefShift   = 20;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [DelayBits-1:0] DelayRst = 17'd13230;
  localparam logic [GainBits-1:0]  GainRst  = 17'd65536;
  localparam logic [CoefBits-1:0]  B0Rst    = 24'd1048576;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DELAY,
    CFG_GAIN,
    CFG_B0,
    CFG_B1,
    CFG_B2,
    CFG_A1,
    CFG_A2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_ADDR,
    ST_DATA,
    ST_X1,
    ST_X2,
    ST_Y1,
    ST_Y2,
    ST_B0,
    ST_SUM,
    ST_FILT,
    ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    OPA_DELAY,
    OPA_X1,
    OPA_X2,
    OPA_Y1,
    OPA_Y2,
    OPA_WET
  } opa_e;

  typedef enum logic [2:0] {
    OPB_GAIN,
    OPB_B0,
    OPB_B1,
    OPB_B2,
    OPB_A1,
    OPB_A2
  } opb_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_e;

  typedef struct packed {
    logic in_ready;
    logic red;
    logic rd_issue;
    opa_e opa;
    opb_e opb;
    acc_e acc;
    logic ld_wet;
    logic ld_filt;
    logic ld_out;
  } step_t;

endpackage

// ===== sv/edh_ram.sv =====
// generic single-clock ram, one write and one registered read port
module edh_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/edh_mac.sv =====
// shared multiplier with registered product and accumulator
module edh_mac (
  input  logic                                 clk_i,
  input  logic signed [edh_pkg::MulABits-1:0]  op_a_i,
  input  logic signed [edh_pkg::MulBBits-1:0]  op_b_i,
  input  edh_pkg::acc_e                        acc_op_i,
  output logic signed [edh_pkg::ProdBits-1:0]  prod_o,
  output logic signed [edh_pkg::AccBits-1:0]   acc_o
);
  import edh_pkg::*;

  logic signed [ProdBits-1:0] prod_q;
  logic signed [AccBits-1:0]  acc_q, acc_d;
  logic signed [AccBits-1:0]  prod_ext;

  assign prod_ext = {{(AccBits - ProdBits){prod_q[ProdBits-1]}}, prod_q};

  always_comb begin
    case (acc_op_i)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== sv/edh_ctrl.sv =====
// sequencer that steps one word through the shared multiply-accumulate unit
module edh_ctrl #(
  parameter int unsigned RED_STEPS = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           red_last_i,
  input  logic           out_free_i,
  output edh_pkg::step_t step_o
);
  import edh_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    step_o.in_ready = 1'b0;
    step_o.red      = 1'b0;
    step_o.rd_issue = 1'b0;
    step_o.opa      = OPA_DELAY;
    step_o.opb      = OPB_GAIN;
    step_o.acc      = ACC_HOLD;
    step_o.ld_wet   = 1'b0;
    step_o.ld_filt  = 1'b0;
    step_o.ld_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        step_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = (RED_STEPS > 0) ? ST_RED : ST_ADDR;
        end
      end
      ST_RED: begin
        step_o.red = 1'b1;
        if (red_last_i) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        step_o.rd_issue = 1'b1;
        state_d = ST_DATA;
      end
      ST_DATA: begin
        step_o.opa = OPA_DELAY;
        step_o.opb = OPB_GAIN;
        state_d = ST_X1;
      end
      ST_X1: begin
        // scaled echo leaves the product register here
        step_o.ld_wet = 1'b1;
        step_o.opa = OPA_X1;
        step_o.opb = OPB_B1;
        state_d = ST_X2;
      end
      ST_X2: begin
        step_o.acc = ACC_LOAD;
        step_o.opa = OPA_X2;
        step_o.opb = OPB_B2;
        state_d = ST_Y1;
      end
      ST_Y1: begin
        step_o.acc = ACC_ADD;
        step_o.opa = OPA_Y1;
        step_o.opb = OPB_A1;
        state_d = ST_Y2;
      end
      ST_Y2: begin
        step_o.acc = ACC_SUB;
        step_o.opa = OPA_Y2;
        step_o.opb = OPB_A2;
        state_d = ST_B0;
      end
      ST_B0: begin
        step_o.acc = ACC_SUB;
        step_o.opa = OPA_WET;
        step_o.opb = OPB_B0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        step_o.acc = ACC_ADD;
        state_d = ST_FILT;
      end
      ST_FILT: begin
        step_o.ld_filt = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          step_o.ld_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/echo_delay_with_highpass.sv =====
// top level: stereo delay line, echo gain, biquad highpass and dry mix
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: in_sample, tuser: channel
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: out_sample, tuser: out_channel
//  cfg      in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
//  a word passes R = clog2(ceil(2^17 / DELAY_DEPTH)) delay reduction steps (0 at the
//  default depth); six products run in turn through one multiplier.
//  no clearing pass after reset: a per-channel wrap flag makes unwritten entries read 0.
//  a finished word waits in the output register while the next word is taken;
//  the sequencer holds in its last step only while that register is still full.
module echo_delay_with_highpass #(
  parameter int unsigned DELAY_DEPTH = edh_pkg::DelayDepthDef,
  parameter int unsigned SAMPLE_BITS = edh_pkg::SampleBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // in_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // channel
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_sample
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // out_channel
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [edh_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [edh_pkg::CfgDataBits-1:0]      cfg_data_i
);
  import edh_pkg::*;

  localparam int unsigned AddrBits    = $clog2(DELAY_DEPTH);
  localparam int unsigned MemDepth    = 2 * DELAY_DEPTH;
  localparam int unsigned MemAddrBits = $clog2(MemDepth);
  localparam int unsigned TdataBits   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned RedSteps    =
    $clog2(((2 ** DelayBits) + DELAY_DEPTH - 1) / DELAY_DEPTH);
  localparam int unsigned RedBits     = (AddrBits + 1 > DelayBits) ? AddrBits + 1 : DelayBits;
  localparam int unsigned RedTop      =
    (RedSteps > 0) ? (DELAY_DEPTH << (RedSteps - 1)) : DELAY_DEPTH;
  localparam longint SMax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SMin = -(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam longint YMax = (64'sd1 <<< (HistYBits - 1)) - 64'sd1;
  localparam longint YMin = -(64'sd1 <<< (HistYBits - 1));

  // configuration registers
  logic [DelayBits-1:0]       delay_q;
  logic [GainBits-1:0]        gain_q;
  logic signed [CoefBits-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayRst;
      gain_q  <= GainRst;
      b0_q    <= B0Rst;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DELAY: delay_q <= cfg_data_i[DelayBits-1:0];
        CFG_GAIN:  gain_q  <= cfg_data_i[GainBits-1:0];
        CFG_B0:    b0_q    <= cfg_data_i;
        CFG_B1:    b1_q    <= cfg_data_i;
        CFG_B2:    b2_q    <= cfg_data_i;
        CFG_A1:    a1_q    <= cfg_data_i;
        CFG_A2:    a2_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  step_t step;
  logic  in_acc;
  logic  red_last;
  logic  out_free;
  logic  m_valid_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  edh_ctrl #(
    .RED_STEPS (RedSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .red_last_i (red_last),
    .out_free_i (out_free),
    .step_o     (step)
  );

  assign s_axis_tready = step.in_ready;

  // word registers
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic                          ch_q;
  logic [RedBits-1:0]            red_q, dv_q;
  logic                          rd_ok_q;

  // per-channel state
  logic [AddrBits-1:0]            pos_q [2];
  logic [1:0]                     wrap_q;
  logic signed [SAMPLE_BITS-1:0]  x1_q [2];
  logic signed [SAMPLE_BITS-1:0]  x2_q [2];
  logic signed [HistYBits-1:0]    y1_q [2];
  logic signed [HistYBits-1:0]    y2_q [2];

  // delay memory, both channels side by side
  logic                   mem_we;
  logic [MemAddrBits-1:0] mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic [AddrBits-1:0]    wpos;
  logic [AddrBits-1:0]    cur_pos;
  logic [AddrBits-1:0]    dly;
  logic [AddrBits:0]      diff;
  logic [AddrBits-1:0]    rd_pos;

  assign mem_we    = in_acc;
  assign wpos      = pos_q[s_axis_tuser];
  assign mem_waddr = s_axis_tuser ? MemAddrBits'(DELAY_DEPTH) + MemAddrBits'(wpos)
                                  : MemAddrBits'(wpos);

  assign cur_pos = pos_q[ch_q];
  assign dly     = red_q[AddrBits-1:0];
  assign diff    = {1'b0, cur_pos} - {1'b0, dly};
  // behind the write position with wrap by depth
  assign rd_pos  = diff[AddrBits] ? diff[AddrBits-1:0] + AddrBits'(DELAY_DEPTH)
                                  : diff[AddrBits-1:0];
  assign mem_raddr = ch_q ? MemAddrBits'(DELAY_DEPTH) + MemAddrBits'(rd_pos)
                          : MemAddrBits'(rd_pos);

  edh_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MemDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .re_i    (step.rd_issue),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign red_last = (dv_q == RedBits'(DELAY_DEPTH));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q <= s_axis_tdata[SAMPLE_BITS-1:0];
      ch_q  <= s_axis_tuser;
      red_q <= RedBits'(delay_q);
      dv_q  <= RedBits'(RedTop);
    end else if (step.red) begin
      // restoring reduction of the delay by the depth, one quotient bit a step
      if (red_q >= dv_q) begin
        red_q <= red_q - dv_q;
      end
      dv_q <= dv_q >> 1;
    end
    if (step.rd_issue) begin
      rd_ok_q <= !diff[AddrBits] || wrap_q[ch_q];
    end
  end

  // shared multiplier operands
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [SAMPLE_BITS-1:0] wet_q, wet_d;
  logic signed [MulABits-1:0]    op_a;
  logic signed [MulBBits-1:0]    op_b;
  logic signed [ProdBits-1:0]    prod;
  logic signed [AccBits-1:0]     acc;

  assign delayed = rd_ok_q ? mem_rdata : '0;

  always_comb begin
    case (step.opa)
      OPA_DELAY: op_a = {{(MulABits - SAMPLE_BITS){delayed[SAMPLE_BITS-1]}}, delayed};
      OPA_X1:    op_a = {{(MulABits - SAMPLE_BITS){x1_q[ch_q][SAMPLE_BITS-1]}}, x1_q[ch_q]};
      OPA_X2:    op_a = {{(MulABits - SAMPLE_BITS){x2_q[ch_q][SAMPLE_BITS-1]}}, x2_q[ch_q]};
      OPA_Y1:    op_a = {{(MulABits - HistYBits){y1_q[ch_q][HistYBits-1]}}, y1_q[ch_q]};
      OPA_Y2:    op_a = {{(MulABits - HistYBits){y2_q[ch_q][HistYBits-1]}}, y2_q[ch_q]};
      OPA_WET:   op_a = {{(MulABits - SAMPLE_BITS){wet_q[SAMPLE_BITS-1]}}, wet_q};
      default:   op_a = '0;
    endcase
    case (step.opb)
      OPB_GAIN: op_b = {{(MulBBits - GainBits){1'b0}}, gain_q};
      OPB_B0:   op_b = {{(MulBBits - CoefBits){b0_q[CoefBits-1]}}, b0_q};
      OPB_B1:   op_b = {{(MulBBits - CoefBits){b1_q[CoefBits-1]}}, b1_q};
      OPB_B2:   op_b = {{(MulBBits - CoefBits){b2_q[CoefBits-1]}}, b2_q};
      OPB_A1:   op_b = {{(MulBBits - CoefBits){a1_q[CoefBits-1]}}, a1_q};
      OPB_A2:   op_b = {{(MulBBits - CoefBits){a2_q[CoefBits-1]}}, a2_q};
      default:  op_b = '0;
    endcase
  end

  edh_mac u_mac (
    .clk_i    (clk_i),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .acc_op_i (step.acc),
    .prod_o   (prod),
    .acc_o    (acc)
  );

  // rounding (ties up) and saturation
  logic signed [ProdBits-1:0]    wet_rnd;
  logic signed [AccBits-1:0]     y_rnd;
  logic signed [HistYBits-1:0]   y_d, y_q;
  logic signed [HistYBits+1:0]   mix;
  logic [SAMPLE_BITS-1:0]        res;

  assign wet_rnd = (prod + (ProdBits'(1) <<< (GainShift - 1))) >>> GainShift;
  assign y_rnd   = (acc + (AccBits'(1) <<< (CoefShift - 1))) >>> CoefShift;

  always_comb begin
    if (wet_rnd > SMax) begin
      wet_d = SAMPLE_BITS'(SMax);
    end else if (wet_rnd < SMin) begin
      wet_d = SAMPLE_BITS'(SMin);
    end else begin
      wet_d = wet_rnd[SAMPLE_BITS-1:0];
    end
    if (y_rnd > YMax) begin
      y_d = HistYBits'(YMax);
    end else if (y_rnd < YMin) begin
      y_d = HistYBits'(YMin);
    end else begin
      y_d = y_rnd[HistYBits-1:0];
    end
    mix = {{(HistYBits + 2 - SAMPLE_BITS){dry_q[SAMPLE_BITS-1]}}, dry_q}
        + {{2{y_q[HistYBits-1]}}, y_q};
    if (mix > SMax) begin
      res = SAMPLE_BITS'(SMax);
    end else if (mix < SMin) begin
      res = SAMPLE_BITS'(SMin);
    end else begin
      res = mix[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.ld_wet) begin
      wet_q <= wet_d;
    end
    if (step.ld_filt) begin
      y_q <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        pos_q[c] <= '0;
        x1_q[c]  <= '0;
        x2_q[c]  <= '0;
        y1_q[c]  <= '0;
        y2_q[c]  <= '0;
      end
      wrap_q <= '0;
    end else if (step.ld_filt) begin
      x2_q[ch_q] <= x1_q[ch_q];
      x1_q[ch_q] <= wet_q;
      y2_q[ch_q] <= y1_q[ch_q];
      y1_q[ch_q] <= y_d;
      if (cur_pos == AddrBits'(DELAY_DEPTH - 1)) begin
        pos_q[ch_q]  <= '0;
        wrap_q[ch_q] <= 1'b1;
      end else begin
        pos_q[ch_q] <= cur_pos + AddrBits'(1);
      end
    end
  end

  // output register
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   out_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (step.ld_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.ld_out) begin
      out_sample_q <= res;
      out_ch_q     <= ch_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TdataBits'(out_sample_q);
  assign m_axis_tuser  = out_ch_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again while a word is in work");

  a_delay_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.rd_issue |-> (red_q < RedBits'(DELAY_DEPTH)))
    else $error("delay not reduced below depth at read");

  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.rd_issue |-> ({1'b0, mem_raddr} < (MemAddrBits + 1)'(MemDepth)))
    else $error("delay memory read address out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.ld_out |-> (!m_valid_q || m_axis_tready))
    else $error("output register loaded while holding an untaken word");

endmodule
